>>> hdl/double_ended_queue_top_macros.svh
// Assertion macros used by the deque controller.
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define DEQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");
// Next-cycle implication, checked outside reset.
`define DEQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");
`else
`define DEQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DEQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/deq_pkg.sv
// Package with the command, status and state types of the deque.
package deq_pkg;

    // Command codes carried by each input transfer.
    typedef enum logic [2:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_QUERY      = 3'd4
    } t_cmd;

    // Status codes returned with each result.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_LOAD = 1'b1
    } t_state;

endpackage

>>> hdl/deq_ram.sv
// Single-port ring store with a registered read.
module deq_ram #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [DATA_WIDTH-1:0]    i_wdata,
    output logic [DATA_WIDTH-1:0]    o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    // A write takes the port; otherwise the addressed entry is read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/deq_ctrl.sv
// Deque controller: head, count, cached end words and the memory sequencing.
`include "double_ended_queue_top_macros.svh"

module deq_ctrl #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    localparam int IW        = $clog2(DEPTH),
    localparam int CW        = $clog2(DEPTH + 1),
    localparam int SW        = CW + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [2:0]            i_command,
    input  logic [DATA_WIDTH-1:0] i_value,
    output logic                  o_stall,
    input  logic                  i_out_free,
    output logic                  o_res_load,
    output logic [1:0]            o_res_status,
    output logic [DATA_WIDTH-1:0] o_res_front,
    output logic [DATA_WIDTH-1:0] o_res_back,
    output logic [DATA_WIDTH-1:0] o_res_removed,
    output logic [CW-1:0]         o_res_count,
    output logic                  o_ram_we,
    output logic [IW-1:0]         o_ram_addr,
    output logic [DATA_WIDTH-1:0] o_ram_wdata,
    input  logic [DATA_WIDTH-1:0] i_ram_rdata
);

    // Ring position of base plus offset, with offset at most DEPTH.
    function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        begin
            sum = SW'(base) + SW'(off);
            if (sum >= SW'(DEPTH)) begin
                ring_add = IW'(sum - SW'(DEPTH));
            end else begin
                ring_add = IW'(sum);
            end
        end
    endfunction

    deq_pkg::t_state  r_state, n_state;
    logic [IW-1:0]         r_head, n_head;
    logic [CW-1:0]         r_count, n_count;
    logic [DATA_WIDTH-1:0] r_front, n_front;
    logic [DATA_WIDTH-1:0] r_back, n_back;
    logic [DATA_WIDTH-1:0] r_removed, n_removed;
    logic                  r_pend_front, n_pend_front;

    deq_pkg::t_status status;
    deq_pkg::t_cmd    cmd;
    logic             accept;
    logic             need_read;
    logic             is_full;
    logic             is_empty;
    logic [IW-1:0]    head_inc;
    logic [IW-1:0]    head_dec;

    assign cmd      = deq_pkg::t_cmd'(i_command);
    assign o_stall  = !((r_state == deq_pkg::S_IDLE) && i_out_free);
    assign accept   = i_valid && !o_stall;
    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);
    assign head_inc = (r_head == IW'(DEPTH - 1)) ? '0 : r_head + IW'(1);
    assign head_dec = (r_head == '0) ? IW'(DEPTH - 1) : r_head - IW'(1);

    // Next state: a pop that leaves words behind passes through S_LOAD for the read.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            deq_pkg::S_IDLE: begin
                if (accept && need_read) begin
                    n_state = deq_pkg::S_LOAD;
                end
            end
            deq_pkg::S_LOAD: begin
                n_state = deq_pkg::S_IDLE;
            end
            default: begin
                n_state = deq_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath: index updates, memory access and the cached end words.
    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_front      = r_front;
        n_back       = r_back;
        n_removed    = r_removed;
        n_pend_front = r_pend_front;
        status       = deq_pkg::ST_OK;
        need_read    = 1'b0;
        o_ram_we     = 1'b0;
        o_ram_addr   = r_head;
        o_ram_wdata  = i_value;
        o_res_load   = 1'b0;
        unique case (r_state)
            deq_pkg::S_IDLE: begin
                n_removed = '0;
                if (accept) begin
                    unique case (cmd)
                        deq_pkg::CMD_PUSH_BACK: begin
                            if (is_full) begin
                                status = deq_pkg::ST_FULL;
                            end else begin
                                o_ram_we   = 1'b1;
                                o_ram_addr = ring_add(r_head, r_count);
                                n_back     = i_value;
                                if (is_empty) begin
                                    n_front = i_value;
                                end
                                n_count = r_count + CW'(1);
                            end
                        end
                        deq_pkg::CMD_PUSH_FRONT: begin
                            if (is_full) begin
                                status = deq_pkg::ST_FULL;
                            end else begin
                                o_ram_we   = 1'b1;
                                o_ram_addr = head_dec;
                                n_head     = head_dec;
                                n_front    = i_value;
                                if (is_empty) begin
                                    n_back = i_value;
                                end
                                n_count = r_count + CW'(1);
                            end
                        end
                        deq_pkg::CMD_POP_BACK: begin
                            if (is_empty) begin
                                status = deq_pkg::ST_EMPTY;
                            end else begin
                                n_removed = r_back;
                                n_count   = r_count - CW'(1);
                                if (r_count > CW'(1)) begin
                                    need_read    = 1'b1;
                                    o_ram_addr   = ring_add(r_head, r_count - CW'(2));
                                    n_pend_front = 1'b0;
                                end
                            end
                        end
                        deq_pkg::CMD_POP_FRONT: begin
                            if (is_empty) begin
                                status = deq_pkg::ST_EMPTY;
                            end else begin
                                n_removed = r_front;
                                n_head    = head_inc;
                                n_count   = r_count - CW'(1);
                                if (r_count > CW'(1)) begin
                                    need_read    = 1'b1;
                                    o_ram_addr   = head_inc;
                                    n_pend_front = 1'b1;
                                end
                            end
                        end
                        default: begin
                            // Query and unused codes leave everything alone.
                        end
                    endcase
                    o_res_load = !need_read;
                end
            end
            deq_pkg::S_LOAD: begin
                if (r_pend_front) begin
                    n_front = i_ram_rdata;
                end else begin
                    n_back = i_ram_rdata;
                end
                o_res_load = 1'b1;
            end
            default: begin
                o_res_load = 1'b0;
            end
        endcase
    end

    // Result fields show the state after the operation; an empty queue shows zeros.
    assign o_res_status  = status;
    assign o_res_count   = n_count;
    assign o_res_removed = n_removed;
    assign o_res_front   = (n_count == '0) ? '0 : n_front;
    assign o_res_back    = (n_count == '0) ? '0 : n_back;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= deq_pkg::S_IDLE;
            r_head       <= '0;
            r_count      <= '0;
            r_pend_front <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_count      <= n_count;
            r_pend_front <= n_pend_front;
        end
    end

    // Cached end words and the pending removed word.
    always_ff @(posedge i_clk) begin
        r_front   <= n_front;
        r_back    <= n_back;
        r_removed <= n_removed;
    end

    `DEQ_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `DEQ_ASSERT_NXT(a_load_one_cycle, i_clk, i_rst_n, r_state == deq_pkg::S_LOAD,
        r_state == deq_pkg::S_IDLE)
    `DEQ_ASSERT_IMP(a_load_out_free, i_clk, i_rst_n, r_state == deq_pkg::S_LOAD, i_out_free)
    `DEQ_ASSERT_IMP(a_load_no_write, i_clk, i_rst_n, r_state == deq_pkg::S_LOAD, !o_ram_we)

endmodule

>>> hdl/double_ended_queue_top.sv
// Bounded double-ended queue of data words: controller, ring store and result register.
//
// Input channel: i_valid / o_stall with i_command and i_value. A transfer
// pushes a word at the back or front, pops one from either end, or queries.
// Output channel: o_valid / i_stall. Every input transfer yields exactly one
// result: status, front and back words, the removed word and the fill count.
// A push, a query, a refused operation or a pop that empties the queue
// goes straight into the result register. A pop that leaves words behind
// reads the new end word from the ring store, which has a registered read,
// in the S_LOAD state, and loads the result from there. Throughput is one
// item per cycle while no result is held; such a pop stalls input in S_LOAD.
// The result register lets a new item enter while the last result is taken.
// While the receiver stalls a valid result, the result holds and no further item is taken.
// Reset (synchronous, active low) empties the queue; the store keeps no
// valid bits, as no entry outside the stored range is ever used.
module double_ended_queue_top #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    localparam int IW        = $clog2(DEPTH),
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [2:0]            i_command,
    input  logic [DATA_WIDTH-1:0] i_value,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [1:0]            o_status,
    output logic [DATA_WIDTH-1:0] o_front_word,
    output logic [DATA_WIDTH-1:0] o_back_word,
    output logic [DATA_WIDTH-1:0] o_removed_word,
    output logic [CW-1:0]         o_fill_count,
    output logic                  o_is_empty
);

    logic                  out_free;
    logic                  res_load;
    logic [1:0]            res_status;
    logic [DATA_WIDTH-1:0] res_front;
    logic [DATA_WIDTH-1:0] res_back;
    logic [DATA_WIDTH-1:0] res_removed;
    logic [CW-1:0]         res_count;
    logic                  ram_we;
    logic [IW-1:0]         ram_addr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic                  r_out_valid;
    logic [1:0]            r_status;
    logic [DATA_WIDTH-1:0] r_front;
    logic [DATA_WIDTH-1:0] r_back;
    logic [DATA_WIDTH-1:0] r_removed;
    logic [CW-1:0]         r_count;

    // The result register can take a new result when empty or being drained.
    assign out_free = !r_out_valid || !i_stall;

    deq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_command     (i_command),
        .i_value       (i_value),
        .o_stall       (o_stall),
        .i_out_free    (out_free),
        .o_res_load    (res_load),
        .o_res_status  (res_status),
        .o_res_front   (res_front),
        .o_res_back    (res_back),
        .o_res_removed (res_removed),
        .o_res_count   (res_count),
        .o_ram_we      (ram_we),
        .o_ram_addr    (ram_addr),
        .o_ram_wdata   (ram_wdata),
        .i_ram_rdata   (ram_rdata)
    );

    deq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload, loaded only when a new result is ready.
    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_status  <= res_status;
            r_front   <= res_front;
            r_back    <= res_back;
            r_removed <= res_removed;
            r_count   <= res_count;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_front_word   = r_front;
    assign o_back_word    = r_back;
    assign o_removed_word = r_removed;
    assign o_fill_count   = r_count;
    assign o_is_empty     = (r_count == '0);

endmodule

>>> tb/sv/double_ended_queue_top_test.sv
// Self-checking testbench for the bounded double-ended queue with random idling on both sides.
`timescale 1ns / 100ps

module double_ended_queue_top_test;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int RAND_ITEMS = 700;

    // Command codes the block treats as a query.
    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    // One input transfer.
    typedef struct packed {
        logic [2:0]            cmd;
        logic [DATA_WIDTH-1:0] value;
    } t_deq_op;

    // One result transfer.
    typedef struct packed {
        deq_pkg::t_status      status;
        logic [DATA_WIDTH-1:0] front_word;
        logic [DATA_WIDTH-1:0] back_word;
        logic [DATA_WIDTH-1:0] removed_word;
        logic [4:0]            fill_count;
        logic                  is_empty;
    } t_deq_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  drv_valid   = 1'b0;
    logic [2:0]            drv_command = 3'd0;
    logic [DATA_WIDTH-1:0] drv_value   = '0;
    logic                  rcv_stall   = 1'b0;

    logic                  o_stall;
    logic                  o_valid;
    logic [1:0]            o_status;
    logic [DATA_WIDTH-1:0] o_front_word;
    logic [DATA_WIDTH-1:0] o_back_word;
    logic [DATA_WIDTH-1:0] o_removed_word;
    logic [4:0]            o_fill_count;
    logic                  o_is_empty;

    // Items waiting to be offered, and results predicted but not yet seen.
    t_deq_op     op_backlog[$];
    t_deq_result due_results[$];

    // Shadow copy of the queue contents.
    logic [DATA_WIDTH-1:0] shadow_ring[DEPTH];
    logic [3:0]            shadow_head = '0;
    logic [4:0]            shadow_count = '0;

    int items_sent   = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    double_ended_queue_top #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (drv_valid),
        .o_stall        (o_stall),
        .i_command      (drv_command),
        .i_value        (drv_value),
        .o_valid        (o_valid),
        .i_stall        (rcv_stall),
        .o_status       (o_status),
        .o_front_word   (o_front_word),
        .o_back_word    (o_back_word),
        .o_removed_word (o_removed_word),
        .o_fill_count   (o_fill_count),
        .o_is_empty     (o_is_empty)
    );

    // Clock with a 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Applies one command to the shadow queue and returns the result it must give.
    function automatic t_deq_result deque_apply(input logic [2:0] cmd,
                                                input logic [DATA_WIDTH-1:0] val);
        t_deq_result res;
        res = '0;
        res.status = deq_pkg::ST_OK;
        if (cmd == deq_pkg::CMD_PUSH_BACK || cmd == deq_pkg::CMD_PUSH_FRONT) begin
            if (shadow_count >= DEPTH) begin
                res.status = deq_pkg::ST_FULL;
            end else if (cmd == deq_pkg::CMD_PUSH_BACK) begin
                shadow_ring[4'(shadow_head + shadow_count)] = val;
                shadow_count++;
            end else begin
                shadow_head = shadow_head - 4'd1;
                shadow_ring[shadow_head] = val;
                shadow_count++;
            end
        end else if (cmd == deq_pkg::CMD_POP_BACK || cmd == deq_pkg::CMD_POP_FRONT) begin
            if (shadow_count == 0) begin
                res.status = deq_pkg::ST_EMPTY;
            end else if (cmd == deq_pkg::CMD_POP_BACK) begin
                res.removed_word = shadow_ring[4'(shadow_head + shadow_count - 5'd1)];
                shadow_count--;
            end else begin
                res.removed_word = shadow_ring[shadow_head];
                shadow_head = shadow_head + 4'd1;
                shadow_count--;
            end
        end
        // The end words are only read inside the stored range.
        if (shadow_count != 0) begin
            res.front_word = shadow_ring[shadow_head];
            res.back_word  = shadow_ring[4'(shadow_head + shadow_count - 5'd1)];
        end
        res.fill_count = shadow_count;
        res.is_empty   = (shadow_count == 0);
        return res;
    endfunction

    // Random data word, with the all-zero and all-one words favoured.
    function automatic logic [DATA_WIDTH-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    task automatic queue_op(input logic [2:0] cmd, input logic [DATA_WIDTH-1:0] val);
        t_deq_op op;
        op.cmd   = cmd;
        op.value = val;
        op_backlog = {op_backlog, op};
    endtask

    task automatic check_field(input string what, input logic [DATA_WIDTH-1:0] want,
                               input logic [DATA_WIDTH-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch: expected %h, actual %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Sender: offers the backlog, holds a stalled transfer and predicts each accepted one.
    always @(posedge i_clk) begin : driver
        logic    next_valid;
        logic    no_idle;
        t_deq_op op;
        next_valid = drv_valid;
        no_idle    = (items_sent >= 450 && items_sent < 560);
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (drv_valid && !o_stall) begin
                due_results = {due_results, deque_apply(drv_command, drv_value)};
                items_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid && op_backlog.size() != 0 &&
                (no_idle || $urandom_range(0, 99) >= 24)) begin
                op = op_backlog[0];
                op_backlog.delete(0);
                drv_command <= op.cmd;
                drv_value   <= op.value;
                next_valid  = 1'b1;
            end
        end
        drv_valid <= next_valid;
    end

    // Receiver: checks each accepted result and chooses the next stall.
    always @(posedge i_clk) begin : monitor
        t_deq_result want;
        logic        stall;
        if (i_rst_n && o_valid === 1'b1 && !rcv_stall) begin
            results_seen++;
            if (due_results.size() == 0) begin
                $display("%0t ns: unexpected result: expected none, actual status %h",
                         $time, o_status);
                mismatches++;
            end else begin
                want = due_results[0];
                due_results.delete(0);
                check_field("status", DATA_WIDTH'(want.status), DATA_WIDTH'(o_status));
                check_field("front_word", want.front_word, o_front_word);
                check_field("back_word", want.back_word, o_back_word);
                check_field("removed_word", want.removed_word, o_removed_word);
                check_field("fill_count", DATA_WIDTH'(want.fill_count),
                            DATA_WIDTH'(o_fill_count));
                check_field("is_empty", DATA_WIDTH'(want.is_empty), DATA_WIDTH'(o_is_empty));
            end
        end
        // A long hold-off once, so that the block backs up and stalls its input.
        if (hold_left != 0) begin
            stall = 1'b1;
            hold_left--;
        end else if (results_seen == 150 && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 80;
            stall     = 1'b1;
        end else if (results_seen >= 400 && results_seen < 520) begin
            stall = 1'b0;
        end else begin
            stall = ($urandom_range(0, 99) < 24);
        end
        rcv_stall <= stall;
    end

    // Stimulus, reset and end of run.
    initial begin
        int       made;
        int       mode;
        int       len;
        int       r;
        logic [2:0] cmd;

        // Directed part: empty pops, spare codes, extreme words, wrap and the full case.
        queue_op(deq_pkg::CMD_QUERY, pick_word());
        queue_op(deq_pkg::CMD_POP_BACK, pick_word());
        queue_op(deq_pkg::CMD_POP_FRONT, pick_word());
        queue_op(CMD_SPARE_7, '1);
        queue_op(deq_pkg::CMD_PUSH_BACK, '1);
        queue_op(deq_pkg::CMD_PUSH_FRONT, '0);
        queue_op(deq_pkg::CMD_POP_BACK, '0);
        queue_op(deq_pkg::CMD_POP_FRONT, '1);
        for (int k = 0; k < DEPTH; k++) begin
            queue_op((k % 2 == 0) ? deq_pkg::CMD_PUSH_FRONT : deq_pkg::CMD_PUSH_BACK,
                     pick_word());
        end
        queue_op(deq_pkg::CMD_PUSH_BACK, pick_word());
        queue_op(deq_pkg::CMD_PUSH_FRONT, pick_word());
        queue_op(CMD_SPARE_5, pick_word());
        queue_op(CMD_SPARE_6, pick_word());

        // Random part in runs that fill, drain, mix or throw in any code.
        made = 0;
        while (made < RAND_ITEMS) begin
            mode = $urandom_range(0, 9);
            len  = $urandom_range(8, 40);
            for (int k = 0; k < len; k++) begin
                r = $urandom_range(0, 99);
                if (mode <= 2) begin
                    cmd = (r < 85)
                        ? ((r % 2) ? deq_pkg::CMD_PUSH_FRONT : deq_pkg::CMD_PUSH_BACK)
                        : ((r % 2) ? deq_pkg::CMD_POP_FRONT : deq_pkg::CMD_POP_BACK);
                end else if (mode <= 5) begin
                    cmd = (r < 85)
                        ? ((r % 2) ? deq_pkg::CMD_POP_FRONT : deq_pkg::CMD_POP_BACK)
                        : ((r % 2) ? deq_pkg::CMD_PUSH_FRONT : deq_pkg::CMD_PUSH_BACK);
                end else if (mode <= 7) begin
                    cmd = 3'($urandom_range(0, 4));
                end else begin
                    cmd = 3'($urandom_range(0, 7));
                end
                queue_op(cmd, pick_word());
                made++;
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_backlog.size() != 0 || drv_valid || due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/deq_pkg.sv
hdl/deq_ram.sv
hdl/deq_ctrl.sv
hdl/double_ended_queue_top.sv
tb/sv/double_ended_queue_top_test.sv
